// ===== src/htok_pkg.sv =====
// htok_pkg: types, constants and character codes shared by the html tokenizer.
// No dependencies; every other file of the tokenizer imports it.
`timescale 1ns / 1ps
`default_nettype none

package htok_pkg;

  localparam int POSITION_BITS_DEF   = 24;
  localparam int LOOKAHEAD_DEPTH_DEF = 8;

  localparam int TOK_POS_W  = 24;
  localparam int TOK_LEN_W  = 24;
  // bytes after the scanned byte that travel with it; enough for "/script>"
  localparam int SCAN_LA    = 8;
  localparam int AVAIL_W    = 4;
  localparam int SKIP_W     = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int NUM_SLOTS  = 5;
  localparam int SLOT_W     = 3;

  localparam int SCRIPT_LEN = 6;
  localparam int STYLE_LEN  = 5;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // index 0 holds the first letter
  localparam logic [SCRIPT_LEN-1:0][7:0] WORD_SCRIPT = {"t", "p", "i", "r", "c", "s"};
  localparam logic [STYLE_LEN-1:0][7:0]  WORD_STYLE  = {"e", "l", "y", "t", "s"};

  typedef enum logic [2:0] {
    TK_TEXT  = 3'd0,
    TK_OPEN  = 3'd1,
    TK_SLASH = 3'd2,
    TK_NAME  = 3'd3,
    TK_ATTR  = 3'd4,
    TK_KEY   = 3'd5,
    TK_VALUE = 3'd6,
    TK_CLOSE = 3'd7
  } token_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_document;
  } in_item_t;

  typedef struct packed {
    token_kind_e          token_kind;
    logic [TOK_POS_W-1:0] start_offset;
    logic [TOK_LEN_W-1:0] text_length;
    logic                 last_of_run;
  } out_item_t;

  // one byte to scan, with the bytes that follow it
  typedef struct packed {
    logic [7:0]              cur_byte;
    logic [SCAN_LA-1:0][7:0] la_bytes;
    logic [AVAIL_W-1:0]      avail;
    logic                    call_end;
    logic                    doc_end;
  } scan_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// ===== src/htok_front.sv =====
// htok_front: lookahead window and end-of-document drain sequencer.
// Accepts document bytes and pushes scan entries into the queue; uses htok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htok_front
  import htok_pkg::*;
#(
  parameter int LookaheadDepth = LOOKAHEAD_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire in_item_t     in_item_i,
  output logic              in_stall_o,
  input  wire fifo_status_t fifo_status_i,
  output logic              push_o,
  output scan_entry_t       push_entry_o
);

  localparam int WinDepth = LookaheadDepth + 1;
  localparam int FillW    = $clog2(WinDepth);
  localparam int RemW     = $clog2(LookaheadDepth + 2);

  logic [7:0]      win_q [WinDepth];
  logic [7:0]      win_d [WinDepth];
  logic [FillW-1:0] fill_q, fill_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             drain_q, drain_d;
  logic             accept;

  assign in_stall_o = drain_q || fifo_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    rem_d        = rem_q;
    drain_d      = drain_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    if (drain_q) begin
      if (!fifo_status_i.full) begin
        push_o                = 1'b1;
        push_entry_o.cur_byte = win_q[0];
        for (int j = 0; j < SCAN_LA; j++) begin
          push_entry_o.la_bytes[j] = win_q[j+1];
        end
        if (rem_q > RemW'(SCAN_LA)) begin
          push_entry_o.avail = AVAIL_W'(SCAN_LA);
        end else begin
          push_entry_o.avail = AVAIL_W'(rem_q - RemW'(1));
        end
        push_entry_o.call_end = (rem_q == RemW'(1));
        push_entry_o.doc_end  = (rem_q == RemW'(1));
        for (int k = 0; k < WinDepth - 1; k++) begin
          win_d[k] = win_q[k+1];
        end
        rem_d = rem_q - RemW'(1);
        if (rem_q == RemW'(1)) begin
          drain_d = 1'b0;
        end
      end
    end else if (accept) begin
      if (in_item_i.end_of_document) begin
        win_d[fill_q] = in_item_i.data_byte;
        rem_d         = RemW'(fill_q) + RemW'(1);
        drain_d       = 1'b1;
        fill_d        = '0;
      end else if (fill_q == FillW'(LookaheadDepth)) begin
        // window full: the oldest byte leaves for scanning
        push_o                = 1'b1;
        push_entry_o.cur_byte = win_q[0];
        for (int j = 0; j < SCAN_LA; j++) begin
          if (j + 1 == LookaheadDepth) begin
            push_entry_o.la_bytes[j] = in_item_i.data_byte;
          end else begin
            push_entry_o.la_bytes[j] = win_q[j+1];
          end
        end
        push_entry_o.avail    = AVAIL_W'(SCAN_LA);
        push_entry_o.call_end = 1'b1;
        push_entry_o.doc_end  = 1'b0;
        for (int k = 0; k < LookaheadDepth - 1; k++) begin
          win_d[k] = win_q[k+1];
        end
        win_d[LookaheadDepth-1] = in_item_i.data_byte;
      end else begin
        win_d[fill_q] = in_item_i.data_byte;
        fill_d        = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      rem_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      drain_q <= drain_d;
    end
  end

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(LookaheadDepth))
    else $error("window fill beyond depth");

  a_drain_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (rem_q != '0) && in_stall_o)
    else $error("drain without bytes left or input not held");

endmodule

`default_nettype wire

// ===== src/htok_fifo.sv =====
// htok_fifo: short queue of scan entries between front and back.
// Register array with head and tail pointers; uses htok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htok_fifo
  import htok_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire scan_entry_t push_entry_i,
  input  wire logic        pop_i,
  output scan_entry_t      pop_entry_o,
  output fifo_status_t     status_o
);

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  scan_entry_t    mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign pop_entry_o     = mem_q[rd_ptr_q];
  assign status_o.full   = (cnt_q == CntW'(FIFO_DEPTH));
  assign status_o.empty  = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full) && !(pop_i && status_o.empty))
    else $error("queue pushed while full or popped while empty");

endmodule

`default_nettype wire

// ===== src/htok_back.sv =====
// htok_back: scanner state machine, token burst, last-token hold and output register.
// Pops scan entries from htok_fifo and delivers token beats; uses htok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htok_back
  import htok_pkg::*;
#(
  parameter int PosBits = POSITION_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire fifo_status_t fifo_status_i,
  input  wire scan_entry_t  entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output out_item_t         out_item_o
);

  // scanner state
  logic [SKIP_W-1:0]    skip_q, skip_d;
  logic [PosBits-1:0]   pos_q, pos_d;
  logic [TOK_LEN_W-1:0] plen_q, plen_d;
  logic                 in_tag_q, in_tag_d;
  logic                 name_done_q, name_done_d;
  logic                 val_pend_q, val_pend_d;
  logic                 raw_q, raw_d;
  logic [1:0]           match_q, match_d;

  // tokens of the entry being scanned
  out_item_t            slot_tok [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_mask;

  // burst of tokens waiting to go out
  out_item_t            burst_tok_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] mask_q, mask_rest;
  logic                 busy_q, end_q;
  out_item_t            held_q;
  logic                 held_v_q;
  out_item_t            out_q, out_d;
  logic                 out_v_q;

  logic [SLOT_W-1:0]    sel;
  logic                 tok_avail, out_free, can_move, need_flush, do_flush;
  logic                 finishing, burst_free;

  logic [7:0]              c;
  logic [SCAN_LA-1:0][7:0] la;
  logic [AVAIL_W-1:0]      av;
  logic                    m_style, m_script;
  logic                    flush_go, text_go, end_tag_go;
  token_kind_e             flush_kind;
  logic [1:0]              m;
  logic [PosBits-1:0]      flush_start;

  assign c  = entry_i.cur_byte;
  assign la = entry_i.la_bytes;
  assign av = entry_i.avail;

  // raw-text close tag matches
  assign m_style  = (av >= AVAIL_W'(STYLE_LEN + 2)) && (la[0] == CH_SLASH)
                    && (la[STYLE_LEN:1] == WORD_STYLE) && (la[STYLE_LEN+1] == CH_GT);
  assign m_script = (av >= AVAIL_W'(SCRIPT_LEN + 2)) && (la[0] == CH_SLASH)
                    && (la[SCRIPT_LEN:1] == WORD_SCRIPT) && (la[SCRIPT_LEN+1] == CH_GT);

  assign flush_start = pos_q - PosBits'(plen_q);

  // emitter control
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign mask_rest  = mask_q & ~(NUM_SLOTS'(1) << sel);
  assign tok_avail  = |mask_q;
  assign out_free   = !out_v_q || !out_stall_i;
  assign can_move   = tok_avail && (!held_v_q || out_free);
  assign need_flush = busy_q && !tok_avail && end_q && held_v_q;
  assign do_flush   = need_flush && out_free;
  assign finishing  = busy_q && ((!tok_avail && (!end_q || !held_v_q)) || do_flush
                                 || (can_move && (mask_rest == '0) && !end_q));
  assign burst_free = !busy_q || finishing;
  assign pop_o      = burst_free && !fifo_status_i.empty;

  // scanner: next state and token slots for one entry
  always_comb begin
    skip_d      = skip_q;
    pos_d       = pos_q;
    plen_d      = plen_q;
    in_tag_d    = in_tag_q;
    name_done_d = name_done_q;
    val_pend_d  = val_pend_q;
    raw_d       = raw_q;
    match_d     = match_q;
    flush_go    = 1'b0;
    flush_kind  = TK_TEXT;
    text_go     = 1'b0;
    end_tag_go  = 1'b0;
    m           = match_q;
    slot_mask   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_tok[i] = '0;
    end

    if (pop_o) begin
      pos_d = pos_q + PosBits'(1);
      if (skip_q != '0) begin
        skip_d = skip_q - SKIP_W'(1);
      end else if (in_tag_q) begin
        if (c == CH_GT) begin
          end_tag_go               = 1'b1;
          in_tag_d                 = 1'b0;
          slot_mask[1]             = 1'b1;
          slot_tok[1].token_kind   = TK_CLOSE;
          slot_tok[1].start_offset = TOK_POS_W'(pos_q);
        end else if (c == CH_SPACE) begin
          end_tag_go = 1'b1;
        end else if (c == CH_EQ) begin
          val_pend_d = 1'b1;
          flush_go   = 1'b1;
          flush_kind = TK_KEY;
        end else begin
          text_go = 1'b1;
        end
      end else if (c == CH_LT) begin
        if (raw_q) begin
          if (m_style || m_script) begin
            flush_go                 = 1'b1;
            flush_kind               = TK_TEXT;
            slot_mask[4:1]           = 4'b1111;
            slot_tok[1].token_kind   = TK_OPEN;
            slot_tok[1].start_offset = TOK_POS_W'(pos_q);
            slot_tok[2].token_kind   = TK_SLASH;
            slot_tok[2].start_offset = TOK_POS_W'(pos_q + PosBits'(1));
            slot_tok[3].token_kind   = TK_NAME;
            slot_tok[3].start_offset = TOK_POS_W'(pos_q + PosBits'(2));
            slot_tok[4].token_kind   = TK_CLOSE;
            if (m_style) begin
              slot_tok[3].text_length  = TOK_LEN_W'(STYLE_LEN);
              slot_tok[4].start_offset = TOK_POS_W'(pos_q + PosBits'(STYLE_LEN + 2));
              skip_d                   = SKIP_W'(STYLE_LEN + 2);
            end else begin
              slot_tok[3].text_length  = TOK_LEN_W'(SCRIPT_LEN);
              slot_tok[4].start_offset = TOK_POS_W'(pos_q + PosBits'(SCRIPT_LEN + 2));
              skip_d                   = SKIP_W'(SCRIPT_LEN + 2);
            end
            raw_d = 1'b0;
          end else begin
            // unmatched '<' in raw text is ordinary text
            text_go = 1'b1;
          end
        end else begin
          flush_go                 = 1'b1;
          flush_kind               = TK_TEXT;
          in_tag_d                 = 1'b1;
          name_done_d              = 1'b0;
          val_pend_d               = 1'b0;
          slot_mask[1]             = 1'b1;
          slot_tok[1].token_kind   = TK_OPEN;
          slot_tok[1].start_offset = TOK_POS_W'(pos_q);
          if ((av != '0) && (la[0] == CH_SLASH)) begin
            slot_mask[2]             = 1'b1;
            slot_tok[2].token_kind   = TK_SLASH;
            slot_tok[2].start_offset = TOK_POS_W'(pos_q + PosBits'(1));
            skip_d                   = SKIP_W'(1);
          end
        end
      end else begin
        text_go = 1'b1;
      end

      if (end_tag_go) begin
        flush_go = 1'b1;
        if (!name_done_q) begin
          if (((plen_q == TOK_LEN_W'(SCRIPT_LEN)) && match_q[0])
              || ((plen_q == TOK_LEN_W'(STYLE_LEN)) && match_q[1])) begin
            raw_d = 1'b1;
          end
          flush_kind  = TK_NAME;
          name_done_d = 1'b1;
        end else if (val_pend_q) begin
          flush_kind = TK_VALUE;
          val_pend_d = 1'b0;
        end else begin
          flush_kind = TK_ATTR;
        end
      end

      if (text_go) begin
        if (in_tag_q && !name_done_q) begin
          // track whether the tag name is still a prefix of script or style
          m = (plen_q == '0) ? 2'b11 : match_q;
          if (plen_q < TOK_LEN_W'(SCRIPT_LEN)) begin
            if (WORD_SCRIPT[plen_q[2:0]] != c) m[0] = 1'b0;
          end else begin
            m[0] = 1'b0;
          end
          if (plen_q < TOK_LEN_W'(STYLE_LEN)) begin
            if (WORD_STYLE[plen_q[2:0]] != c) m[1] = 1'b0;
          end else begin
            m[1] = 1'b0;
          end
          match_d = m;
        end
        if (plen_q != '1) begin
          plen_d = plen_q + TOK_LEN_W'(1);
        end
      end

      if (flush_go && (plen_q != '0)) begin
        slot_mask[0]             = 1'b1;
        slot_tok[0].token_kind   = flush_kind;
        slot_tok[0].start_offset = TOK_POS_W'(flush_start);
        slot_tok[0].text_length  = plen_q;
        plen_d                   = '0;
      end

      if (entry_i.doc_end) begin
        skip_d      = '0;
        pos_d       = '0;
        plen_d      = '0;
        in_tag_d    = 1'b0;
        name_done_d = 1'b0;
        val_pend_d  = 1'b0;
        raw_d       = 1'b0;
        match_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= '0;
      pos_q       <= '0;
      plen_q      <= '0;
      in_tag_q    <= 1'b0;
      name_done_q <= 1'b0;
      val_pend_q  <= 1'b0;
      raw_q       <= 1'b0;
      match_q     <= '0;
      busy_q      <= 1'b0;
      mask_q      <= '0;
      end_q       <= 1'b0;
      held_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      skip_q      <= skip_d;
      pos_q       <= pos_d;
      plen_q      <= plen_d;
      in_tag_q    <= in_tag_d;
      name_done_q <= name_done_d;
      val_pend_q  <= val_pend_d;
      raw_q       <= raw_d;
      match_q     <= match_d;
      if (pop_o) begin
        busy_q <= 1'b1;
        mask_q <= slot_mask;
        end_q  <= entry_i.call_end;
      end else begin
        if (finishing) begin
          busy_q <= 1'b0;
        end
        if (can_move) begin
          mask_q <= mask_rest;
        end
      end
      if (can_move) begin
        held_v_q <= 1'b1;
      end else if (do_flush) begin
        held_v_q <= 1'b0;
      end
      if (out_free) begin
        out_v_q <= (can_move && held_v_q) || do_flush;
      end
    end
  end

  // the held token is the last of its run once its byte group ends
  always_comb begin
    out_d             = held_q;
    out_d.last_of_run = do_flush;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      burst_tok_q <= slot_tok;
    end
    if (can_move) begin
      held_q <= burst_tok_q[sel];
    end
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  a_skip_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= SKIP_W'(SCRIPT_LEN + 2))
    else $error("skip count beyond longest close tag");

  a_doc_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.doc_end) |=> (pos_q == '0) && (plen_q == '0) && !in_tag_q && !raw_q)
    else $error("scanner state not cleared after document end");

  a_last_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_flush |=> out_valid_o && out_item_o.last_of_run)
    else $error("run end did not deliver a last token");

endmodule

`default_nettype wire

// ===== src/html_tokenizer.sv =====
// html_tokenizer: top level of the byte-serial html tokenizer.
// Instantiates htok_front, htok_fifo and htok_back; uses htok_pkg.
//
//   channel | signals                            | beat
//   --------+------------------------------------+-------------------------------
//   in      | in_valid_i, in_stall_o, in_item_i  | one document byte, end flag
//   out     | out_valid_o, out_stall_i, out_item_o | one token record
//
// Bytes enter at one per cycle while in_stall_o is low; a byte is queued for scanning once
// LOOKAHEAD_DEPTH more bytes are in. The scanner takes one byte per cycle while its token
// burst is free; a byte that gives tokens holds it while they pass the single output
// register and the hold stage that marks last_of_run, and a drained byte other than the final
// one needs no such mark. The final byte of a document holds input while the window drains
// into the queue, and longer when the queue is full; reset clears all control state at once.
// Output stall backs up through the token hold stage, the scanner and the queue.
`timescale 1ns / 1ps
`default_nettype none

module html_tokenizer
  import htok_pkg::*;
#(
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int LOOKAHEAD_DEPTH = LOOKAHEAD_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  fifo_status_t fifo_status;
  logic         push;
  scan_entry_t  push_entry;
  logic         pop;
  scan_entry_t  pop_entry;

  htok_front #(
    .LookaheadDepth(LOOKAHEAD_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .fifo_status_i(fifo_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  htok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .pop_entry_o (pop_entry),
    .status_o    (fifo_status)
  );

  htok_back #(
    .PosBits(POSITION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_status_i(fifo_status),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire
